// ===== sv/pag_pkg.sv =====
// shared constants and types for the preferential attachment generator
`timescale 1ns / 1ps
package pag_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_CLIQUE = 32;
    localparam int MAX_EDGES_PER_VERTEX = 16;
    localparam int LIST_DEPTH = 32768;
    localparam int VW = 10;
    localparam int LW = 15;
    localparam int CW = 5;

    localparam logic [1:0] ST_EDGE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    localparam logic [1:0] REG_CLIQUE = 2'd0;
    localparam logic [1:0] REG_ADD = 2'd1;
    localparam logic [1:0] REG_EPV = 2'd2;

    typedef enum logic [1:0] {PH_CLIQUE, PH_GROWTH, PH_FIN} t_phase;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_RD, S_RDW, S_SCAN, S_EMIT
    } t_state;

    // read response from the list memory unit
    typedef struct packed {
        logic [VW-1:0] rd_data;
    } t_mem_rsp;
endpackage

// ===== sv/pag_list_mem.sv =====
// endpoint list memory, one write and one registered read per cycle
`timescale 1ns / 1ps
module pag_list_mem import pag_pkg::*; (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [LW-1:0] i_waddr,
    input  logic [VW-1:0] i_wdata,
    input  logic [LW-1:0] i_raddr,
    output t_mem_rsp      o_rsp
);
    logic [VW-1:0] r_mem [LIST_DEPTH];
    logic [VW-1:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_raddr];
    end

    assign o_rsp.rd_data = r_rd;
endmodule

// ===== sv/preferential_attachment_graph_gen_core.sv =====
// top level of the preferential attachment graph generator
// timing: clique and status beats appear in the cycle after accept; a growth item that fills
// the chosen set passes S_MUL0, S_RD, S_RDW, S_SCAN and S_EMIT before its first edge beat
// a new item is taken only when busy is low, after the last list write of the one before;
// pacing is set by the multiplier, the scan and two list writes per edge
// reset: synchronous active low, control and configuration registers to defaults; results cannot be held off
`timescale 1ns / 1ps
module preferential_attachment_graph_gen_core import pag_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [30:0]   i_random_fraction,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [9:0]    i_cfg_data,
    output logic          o_valid,
    output logic [VW-1:0] o_edge_from,
    output logic [VW-1:0] o_edge_to,
    output logic [1:0]    o_status,
    output logic          o_last
);
    logic [5:0] r_clique;
    logic [9:0] r_add;
    logic [4:0] r_epv;
    t_phase r_phase;
    t_state r_state, n_state;
    logic [LW-1:0] r_len;
    logic [CW-1:0] r_cnt, r_i;
    logic [4:0] r_row, r_col;
    logic [9:0] r_vadd;
    logic [30:0] r_frac;
    logic [LW+31-1:0] r_prod;
    logic [VW-1:0] r_v, r_hold, r_newv;
    logic r_seen, r_ins;
    logic [VW-1:0] r_set [MAX_EDGES_PER_VERTEX];
    logic [1:0] r_wph;
    logic r_ov, n_ov;
    logic [VW-1:0] r_of, r_ot;
    logic [1:0] r_os;
    logic r_ol;
    t_mem_rsp w_rsp;
    logic w_we;
    logic [LW-1:0] w_waddr, w_raddr;
    logic [VW-1:0] w_wdata;
    logic w_ok;
    logic w_acc;
    logic [16:0] w_need;

    // configuration check
    always_comb begin
        w_need = 17'(r_clique) * 17'(r_clique - 6'd1) + 17'({r_add, 1'b0}) * 17'(r_epv);
        w_ok = (r_clique >= 6'd2) && (r_clique <= 6'(MAX_CLIQUE))
            && ({1'b0, r_epv} <= r_clique) && (r_epv <= 5'(MAX_EDGES_PER_VERTEX))
            && (11'(r_clique) + 11'(r_add) <= 11'(MAX_VERTICES))
            && (w_need <= 17'(LIST_DEPTH));
    end

    pag_list_mem u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rsp(w_rsp)
    );

    assign w_raddr = r_prod[LW+30:31];
    // busy until the list writes of the last edge are done
    assign busy = (r_state != S_IDLE) || (r_wph != 2'd0);
    assign w_acc = start && !busy;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (!w_ok || r_phase != PH_GROWTH) n_state = S_IDLE;
                    else if (r_cnt < r_epv && r_len != '0) n_state = S_MUL0;
                    else if (r_cnt >= r_epv && r_cnt != '0) n_state = S_EMIT;
                end
            end
            S_MUL0: n_state = S_RD;
            S_RD:   n_state = S_RDW;
            S_RDW:  n_state = S_SCAN;
            S_SCAN: begin
                if (r_i == r_cnt) begin
                    if (!r_seen && r_cnt + 5'd1 >= r_epv) n_state = S_EMIT;
                    else n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (r_i == r_cnt - 5'd1 && r_wph == 2'd1) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result strobe: clique and status beats at accept, edge beats in the emit slot
    always_comb begin
        n_ov = 1'b0;
        if (i_rst_n && !i_cfg_we) begin
            if (w_acc && (!w_ok || r_phase != PH_GROWTH)) n_ov = 1'b1;
            else if (r_state == S_EMIT && r_wph == 2'd0) n_ov = 1'b1;
        end
    end

    // list write: two endpoints per edge, in write phases one and two
    always_comb begin
        w_we = 1'b0;
        w_waddr = r_len;
        w_wdata = r_v;
        if (r_wph == 2'd1 || r_wph == 2'd2) begin
            w_we = 1'b1;
            w_wdata = (r_wph == 2'd1) ? r_hold : r_newv;
        end
    end

    // result strobe register
    always_ff @(posedge i_clk) begin
        r_ov <= n_ov;
    end

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            if (!i_rst_n) begin
                r_clique <= 6'd4; r_add <= 10'd100; r_epv <= 5'd2;
            end else begin
                case (i_cfg_index)
                    REG_CLIQUE: r_clique <= i_cfg_data[5:0];
                    REG_ADD:    r_add <= i_cfg_data;
                    REG_EPV:    r_epv <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (!i_rst_n || (i_cfg_index inside {REG_CLIQUE, REG_ADD, REG_EPV})) begin
                r_phase <= PH_CLIQUE; r_len <= '0; r_cnt <= '0; r_row <= '0;
                r_col <= 5'd1; r_vadd <= '0;
            end
            r_state <= S_IDLE; r_wph <= 2'd0; r_i <= '0;
        end else begin
            r_state <= n_state;
            if (r_wph == 2'd1) r_wph <= 2'd2;
            else if (r_wph == 2'd2) r_wph <= 2'd0;
            if (w_we) r_len <= r_len + 15'd1;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_frac <= i_random_fraction;
                        r_i <= '0;
                        if (!w_ok) begin
                            r_of <= '0; r_ot <= '0; r_os <= ST_ERR; r_ol <= 1'b1;
                        end else if (r_phase == PH_CLIQUE) begin
                            r_of <= 10'(r_row); r_ot <= 10'(r_col);
                            r_os <= ST_EDGE; r_ol <= 1'b1;
                            r_hold <= 10'(r_row); r_newv <= 10'(r_col); r_wph <= 2'd1;
                            if (6'(r_col) + 6'd1 >= r_clique) begin
                                r_row <= r_row + 5'd1;
                                r_col <= r_row + 5'd2;
                                if (6'(r_row) + 6'd2 >= r_clique)
                                    r_phase <= (r_add == '0) ? PH_FIN : PH_GROWTH;
                            end else begin
                                r_col <= r_col + 5'd1;
                            end
                        end else if (r_phase == PH_FIN) begin
                            r_of <= '0; r_ot <= '0; r_os <= ST_DONE; r_ol <= 1'b1;
                        end else begin
                            r_newv <= 10'(r_clique) + r_vadd;
                            if (r_cnt >= r_epv && r_cnt == '0) begin
                                r_vadd <= r_vadd + 10'd1;
                                if (r_vadd + 10'd1 >= r_add) r_phase <= PH_FIN;
                            end
                        end
                    end
                end
                // multiply for the list index
                S_MUL0: r_prod <= 46'(r_frac) * 46'(r_len);
                S_RD: ;
                S_RDW: begin
                    r_v <= w_rsp.rd_data; r_seen <= 1'b0; r_ins <= 1'b0;
                end
                // one chosen entry a cycle: membership test and sorted insert
                S_SCAN: begin
                    if (r_i == r_cnt) begin
                        if (!r_seen) begin
                            r_set[r_i[3:0]] <= r_ins ? r_hold : r_v;
                            r_cnt <= r_cnt + 5'd1;
                            if (r_cnt + 5'd1 >= r_epv) r_i <= '0;
                        end
                    end else begin
                        r_i <= r_i + 5'd1;
                        if (r_set[r_i[3:0]] == r_v) r_seen <= 1'b1;
                        if (!r_seen && r_set[r_i[3:0]] != r_v) begin
                            if (r_ins) begin
                                r_set[r_i[3:0]] <= r_hold; r_hold <= r_set[r_i[3:0]];
                            end else if (r_set[r_i[3:0]] > r_v) begin
                                r_set[r_i[3:0]] <= r_v; r_hold <= r_set[r_i[3:0]];
                                r_ins <= 1'b1;
                            end
                        end
                    end
                end
                // one edge beat and two list writes per chosen vertex
                S_EMIT: begin
                    if (r_wph == 2'd0) begin
                        r_of <= r_set[r_i[3:0]]; r_ot <= r_newv;
                        r_os <= ST_EDGE; r_ol <= (r_i == r_cnt - 5'd1);
                        r_hold <= r_set[r_i[3:0]]; r_wph <= 2'd1;
                    end else if (r_wph == 2'd1) begin
                        if (r_i == r_cnt - 5'd1) begin
                            r_cnt <= '0;
                            r_vadd <= r_vadd + 10'd1;
                            if (r_vadd + 10'd1 >= r_add) r_phase <= PH_FIN;
                        end
                        r_i <= r_i + 5'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_edge_from = r_of;
    assign o_edge_to = r_ot;
    assign o_status = r_os;
    assign o_last = r_ol;

`ifndef SYNTH
    // the chosen count never exceeds the set depth
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 5'(MAX_EDGES_PER_VERTEX)) else $error("chosen count overflow");
    // an error beat is always the last beat of its item
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_ERR) |-> o_last) else $error("error beat not last");
    // the drawn index stays inside the filled part of the list
    a_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDW) |-> (r_prod[LW+30:31] < r_len)) else $error("index out of range");
`endif
endmodule

// ===== verif/tb_preferential_attachment_graph_gen_core.sv =====
// testbench for the preferential attachment graph generator core
`timescale 1ns / 1ps
module tb_preferential_attachment_graph_gen_core;
    import pag_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [VW-1:0] from_v;
        logic [VW-1:0] to_v;
        logic [1:0]    status;
        logic          last;
    } t_edge_beat;

    // directed rows: either a register write or one item, optionally with a typed result
    typedef struct {
        bit            is_cfg;
        logic [1:0]    idx;
        logic [9:0]    data;
        logic [30:0]   frac;
        bit            typed;
        t_edge_beat    want;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [30:0]   i_random_fraction;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_index;
    logic [9:0]    i_cfg_data;
    logic          o_valid;
    logic [VW-1:0] o_edge_from;
    logic [VW-1:0] o_edge_to;
    logic [1:0]    o_status;
    logic          o_last;

    preferential_attachment_graph_gen_core uut (.*);

    // generator state mirrored in the bench
    logic [5:0]    g_clique;
    logic [9:0]    g_add;
    logic [4:0]    g_epv;
    logic [VW-1:0] ends_mem [0:LIST_DEPTH-1];
    int unsigned   ends_len;
    logic [VW-1:0] picked [0:MAX_EDGES_PER_VERTEX-1];
    int unsigned   picked_cnt;
    t_phase        g_phase;
    int unsigned   row_i;
    int unsigned   col_i;
    int unsigned   grown;

    t_edge_beat    edges_due [$];
    t_edge_beat    step_beats [$];
    int            mismatches = 0;
    int            cycles = 0;
    bit            no_idle;

    // clock, 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_edge_beat mk(int f, int t, logic [1:0] s, bit l);
        t_edge_beat b;
        b.from_v = f[VW-1:0];
        b.to_v = t[VW-1:0];
        b.status = s;
        b.last = l;
        return b;
    endfunction

    function automatic bit cfg_good();
        longint need;
        if (g_clique < 2 || g_clique > MAX_CLIQUE) return 0;
        if (g_epv > g_clique || g_epv > MAX_EDGES_PER_VERTEX) return 0;
        if (int'(g_clique) + int'(g_add) > MAX_VERTICES) return 0;
        need = longint'(g_clique) * (g_clique - 1) + 2 * longint'(g_add) * g_epv;
        return need <= LIST_DEPTH;
    endfunction

    function automatic void restart_gen();
        ends_len = 0;
        picked_cnt = 0;
        g_phase = PH_CLIQUE;
        row_i = 0;
        col_i = 1;
        grown = 0;
    endfunction

    function automatic void push_end(int unsigned v);
        if (ends_len < LIST_DEPTH) begin
            ends_mem[ends_len] = v[VW-1:0];
            ends_len++;
        end
    endfunction

    // one item through the generator; beats land in step_beats
    function automatic void gen_step(logic [30:0] frac);
        longint unsigned prod;
        int unsigned pos_i, pick_i, newv;
        logic [VW-1:0] v;
        bit seen;
        step_beats.delete();
        if (!cfg_good()) begin
            step_beats = {step_beats, mk(0, 0, ST_ERR, 1)};
            return;
        end
        if (g_phase == PH_CLIQUE) begin
            step_beats = {step_beats, mk(row_i, col_i, ST_EDGE, 1)};
            push_end(row_i);
            push_end(col_i);
            col_i++;
            if (col_i >= g_clique) begin
                row_i++;
                col_i = row_i + 1;
                if (col_i >= g_clique) g_phase = (g_add == 0) ? PH_FIN : PH_GROWTH;
            end
            return;
        end
        if (g_phase != PH_GROWTH) begin
            step_beats = {step_beats, mk(0, 0, ST_DONE, 1)};
            return;
        end
        // draw one endpoint, insert it sorted unless already picked
        if (picked_cnt < g_epv && ends_len > 0) begin
            prod = (longint'(frac) * ends_len) >> 31;
            pick_i = (prod >= ends_len) ? ends_len - 1 : int'(prod);
            v = ends_mem[pick_i];
            seen = 0;
            pos_i = picked_cnt;
            for (int i = 0; i < picked_cnt; i++) begin
                if (picked[i] == v) seen = 1;
                if (pos_i == picked_cnt && picked[i] > v) pos_i = i;
            end
            if (!seen && picked_cnt < MAX_EDGES_PER_VERTEX) begin
                for (int i = picked_cnt; i > pos_i; i--) picked[i] = picked[i-1];
                picked[pos_i] = v;
                picked_cnt++;
            end
        end
        if (picked_cnt < g_epv) return;
        newv = g_clique + grown;
        for (int k = 0; k < picked_cnt; k++) begin
            step_beats = {step_beats, mk(picked[k], newv, ST_EDGE, k + 1 == picked_cnt)};
            push_end(picked[k]);
            push_end(newv);
        end
        picked_cnt = 0;
        grown++;
        if (grown >= g_add) g_phase = PH_FIN;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_edge_beat got, want;
        if (i_rst_n && o_valid) begin
            got = mk(o_edge_from, o_edge_to, o_status, o_last);
            if (edges_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %p", got);
            end else begin
                want = edges_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // idle register write once all results are back
    task automatic write_reg(logic [1:0] idx, logic [9:0] data);
        while (edges_due.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CLIQUE: begin g_clique = data[5:0]; restart_gen(); end
            REG_ADD:    begin g_add = data; restart_gen(); end
            REG_EPV:    begin g_epv = data[4:0]; restart_gen(); end
            default: ;
        endcase
    endtask

    // hand one item over; start stays high unless an idle gap follows
    task automatic send_item(logic [30:0] frac, bit typed, t_edge_beat want);
        start <= 1'b1;
        i_random_fraction <= frac;
        do @(posedge i_clk); while (busy);
        gen_step(frac);
        if (typed) edges_due = {edges_due, want};
        else edges_due = {edges_due, step_beats};
        if (!no_idle && $urandom_range(99) < 34) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic t_row item_row(logic [30:0] frac);
        t_row r;
        r = '{0, 0, 0, frac, 0, mk(0, 0, 0, 0)};
        return r;
    endfunction

    function automatic t_row typed_row(logic [30:0] frac, t_edge_beat want);
        t_row r;
        r = '{0, 0, 0, frac, 1, want};
        return r;
    endfunction

    function automatic t_row cfg_row(logic [1:0] idx, logic [9:0] data);
        t_row r;
        r = '{1, idx, data, 0, 0, mk(0, 0, 0, 0)};
        return r;
    endfunction

    initial begin
        t_row plan [$];
        int phase_items;
        logic [9:0] cfg_set [0:7][0:2];
        no_idle = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_random_fraction = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        g_clique = 4;
        g_add = 100;
        g_epv = 2;
        restart_gen();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset: the complete graph on four vertices
        plan = {plan, typed_row(31'h7FFF_FFFF, mk(0, 1, ST_EDGE, 1))};
        plan = {plan, typed_row(31'h0, mk(0, 2, ST_EDGE, 1))};
        plan = {plan, typed_row(31'h2AAA_AAAA, mk(0, 3, ST_EDGE, 1))};
        plan = {plan, typed_row(31'h5555_5555, mk(1, 2, ST_EDGE, 1))};
        plan = {plan, typed_row(31'h0, mk(1, 3, ST_EDGE, 1))};
        plan = {plan, typed_row(31'h0, mk(2, 3, ST_EDGE, 1))};
        // growth: repeated draw of the first entry, then extremes of the fraction
        plan = {plan, item_row(31'h0)};
        plan = {plan, item_row(31'h0)};
        plan = {plan, item_row(31'h7FFF_FFFF)};
        plan = {plan, item_row(31'h4000_0000)};
        plan = {plan, item_row(31'h7FFF_FFFF)};
        // bad configuration: more edges per vertex than clique vertices
        plan = {plan, cfg_row(REG_EPV, 10'd5)};
        plan = {plan, typed_row(31'h1234_5678, mk(0, 0, ST_ERR, 1))};
        plan = {plan, typed_row(31'h0, mk(0, 0, ST_ERR, 1))};
        // zero edges per vertex, then generation finished
        plan = {plan, cfg_row(REG_CLIQUE, 10'd2)};
        plan = {plan, cfg_row(REG_ADD, 10'd3)};
        plan = {plan, cfg_row(REG_EPV, 10'd0)};
        plan = {plan, typed_row(31'h0, mk(0, 1, ST_EDGE, 1))};
        plan = {plan, item_row(31'h1)};
        plan = {plan, item_row(31'h2)};
        plan = {plan, item_row(31'h3)};
        plan = {plan, typed_row(31'h7FFF_FFFF, mk(0, 0, ST_DONE, 1))};
        plan = {plan, typed_row(31'h0, mk(0, 0, ST_DONE, 1))};
        // unused register index changes nothing
        plan = {plan, cfg_row(REG_SPARE, 10'h3FF)};
        plan = {plan, typed_row(31'h0, mk(0, 0, ST_DONE, 1))};

        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                start <= 1'b0;
                write_reg(plan[n].idx, plan[n].data);
            end else begin
                send_item(plan[n].frac, plan[n].typed, plan[n].want);
            end
        end

        // register settings for the random phases: clique, add, edges per vertex
        cfg_set = '{
            '{10'd4, 10'd30, 10'd2}, '{10'd3, 10'd20, 10'd1},
            '{10'd16, 10'd40, 10'd16}, '{10'd32, 10'd992, 10'd16},
            '{10'd6, 10'd0, 10'd3}, '{10'd63, 10'd1023, 10'd31},
            '{10'd5, 10'd12, 10'd5}, '{10'd2, 10'd1, 10'd2}
        };
        for (int p = 0; p < 8; p++) begin
            start <= 1'b0;
            write_reg(REG_CLIQUE, cfg_set[p][0]);
            write_reg(REG_ADD, cfg_set[p][1]);
            write_reg(REG_EPV, cfg_set[p][2]);
            phase_items = (p == 0) ? 80 : 28;
            no_idle = (p == 2);
            for (int n = 0; n < phase_items; n++) begin
                if (p == 0 && n == 40) begin
                    start <= 1'b0;
                    while (edges_due.size() != 0) @(posedge i_clk);
                end
                send_item(31'($urandom()), 0, mk(0, 0, 0, 0));
            end
        end
        start <= 1'b0;

        while (edges_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && edges_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/pag_pkg.sv
sv/pag_list_mem.sv
sv/preferential_attachment_graph_gen_core.sv
verif/tb_preferential_attachment_graph_gen_core.sv
